@@ src/brav_pkg.sv @@
// Shared types and constants for the baseline ratio averager.
// No dependencies; every other file except brav_if imports this package.
`default_nettype none
package brav_pkg;

	localparam int RATIO_FRAC_BITS = 12;
	localparam int DIV_W           = 33;
	localparam int DSR_W           = 16;
	localparam int DIV_CNT_W       = $clog2(DIV_W + 1);
	localparam logic [15:0] CNT_FULL  = 16'hFFFF;
	localparam logic [15:0] RATIO_MAX = 16'hFFFF;

	localparam logic [31:0] DURATION_RESET = 32'd60000;
	localparam logic [15:0] MIN_RESET      = 16'd100;

	typedef enum logic {
		CFG_DURATION = 1'b0,
		CFG_MIN      = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		DIV_RATIO,
		DIV_RED,
		DIV_IR,
		DIV_RSUM
	} div_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_RAT_GO,
		ST_RAT_WAIT,
		ST_CHECK,
		ST_AVR_GO,
		ST_AVR_WAIT,
		ST_AVI_GO,
		ST_AVI_WAIT,
		ST_AVQ_GO,
		ST_AVQ_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic     load_in;
		logic     do_start;
		logic     do_accum;
		logic     do_close;
		logic     div_start;
		div_sel_t div_sel;
		logic     load_out;
	} cmd_t;

	typedef struct packed {
		logic is_start;
		logic armed;
		logic pair_ok;
		logic close_hit;
		logic success;
		logic cnt_zero;
		logic div_busy;
		logic div_done;
	} stat_t;

endpackage
`default_nettype wire

@@ src/brav_if.sv @@
// Item channel interfaces: sample/start input and result output.
// Valid/ready handshake; no dependencies.
`default_nettype none
interface brav_in_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic signed [15:0] red_sample;
	logic signed [15:0] ir_sample;
	logic [31:0]        now_ms;

	modport source(output valid, func, red_sample, ir_sample, now_ms, input ready);
	modport sink(input valid, func, red_sample, ir_sample, now_ms, output ready);
endinterface

interface brav_out_if;
	logic        valid;
	logic        ready;
	logic        capturing;
	logic        done_res;
	logic        success;
	logic [14:0] avg_red;
	logic [14:0] avg_ir;
	logic [15:0] avg_ratio;
	logic [15:0] valid_count;

	modport source(output valid, capturing, done_res, success, avg_red, avg_ir,
		avg_ratio, valid_count, input ready);
	modport sink(input valid, capturing, done_res, success, avg_red, avg_ir,
		avg_ratio, valid_count, output ready);
endinterface
`default_nettype wire

@@ src/brav_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on brav_pkg.
`default_nettype none
module brav_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [brav_pkg::DIV_W-1:0] dividend,
	input  wire logic [brav_pkg::DSR_W-1:0] divisor,
	output logic                            busy,
	output logic                            done,
	output logic [brav_pkg::DIV_W-1:0]      quotient
);
	import brav_pkg::*;

	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DSR_W-1:0]     rem_q;
	logic [DSR_W-1:0]     dsr_q;
	logic [DIV_W-1:0]     quo_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DSR_W:0]       trial;
	logic [DSR_W:0]       diff;
	logic                 qbit;

	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		diff  = trial - {1'b0, dsr_q};
		qbit  = (trial >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], qbit};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

@@ src/brav_dp.sv @@
// Datapath: input and config registers, window state, sums, result register.
// Depends on brav_pkg and brav_div.
`default_nettype none
module brav_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire brav_pkg::cfg_idx_t cfg_idx,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               func,
	input  wire logic signed [15:0] red_sample,
	input  wire logic signed [15:0] ir_sample,
	input  wire logic [31:0]        now_ms,
	input  wire brav_pkg::cmd_t     cmd,
	output brav_pkg::stat_t         stat,
	output logic                    capturing,
	output logic                    done_res,
	output logic                    success,
	output logic [14:0]             avg_red,
	output logic [14:0]             avg_ir,
	output logic [15:0]             avg_ratio,
	output logic [15:0]             valid_count
);
	import brav_pkg::*;

	logic [31:0] dur_q;
	logic [15:0] min_q;

	logic              func_q;
	logic signed [15:0] red_q;
	logic signed [15:0] ir_q;
	logic [31:0]       now_q;

	logic        armed_q;
	logic [31:0] ws_q;
	logic [30:0] red_sum_q;
	logic [30:0] ir_sum_q;
	logic [31:0] ratio_sum_q;
	logic [15:0] count_q;

	logic        done_q;
	logic        succ_q;
	logic [14:0] avg_red_q;
	logic [14:0] avg_ir_q;
	logic [15:0] avg_ratio_q;

	logic [14:0] red_mag;
	logic [14:0] ir_mag;
	logic        red_ok;
	logic        ir_ok;
	logic        lo_ok;
	logic        hi_ok;
	logic [31:0] elapsed;
	logic [15:0] ratio_sat;

	logic [DIV_W-1:0] div_dvd;
	logic [DSR_W-1:0] div_dsr;
	logic [DIV_W-1:0] div_quo;
	logic             div_busy;
	logic             div_done;

	always_comb begin
		red_mag   = red_q[14:0];
		ir_mag    = ir_q[14:0];
		red_ok    = !red_q[15] && (red_mag > 15'd1);
		ir_ok     = !ir_q[15] && (ir_mag > 15'd1);
		lo_ok     = (22'(red_mag) * 22'd100) > 22'(ir_mag);
		hi_ok     = 19'(red_mag) < (19'(ir_mag) * 19'd10);
		elapsed   = now_q - ws_q;
		ratio_sat = (div_quo > DIV_W'(RATIO_MAX)) ? RATIO_MAX : div_quo[15:0];
	end

	always_comb begin
		stat.is_start  = func_q;
		stat.armed     = armed_q;
		stat.pair_ok   = red_ok && ir_ok && lo_ok && hi_ok && (count_q != CNT_FULL);
		stat.close_hit = (elapsed >= dur_q);
		stat.success   = (count_q >= min_q);
		stat.cnt_zero  = (count_q == 16'd0);
		stat.div_busy  = div_busy;
		stat.div_done  = div_done;
	end

	always_comb begin
		div_dsr = count_q;
		case (cmd.div_sel)
			DIV_RATIO: begin
				div_dvd = DIV_W'(red_mag) << RATIO_FRAC_BITS;
				div_dsr = DSR_W'(ir_mag);
			end
			DIV_RED:  div_dvd = DIV_W'(red_sum_q) + DIV_W'(count_q[15:1]);
			DIV_IR:   div_dvd = DIV_W'(ir_sum_q) + DIV_W'(count_q[15:1]);
			DIV_RSUM: div_dvd = DIV_W'(ratio_sum_q) + DIV_W'(count_q[15:1]);
			default:  div_dvd = '0;
		endcase
	end

	brav_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q <= DURATION_RESET;
			min_q <= MIN_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_DURATION: dur_q <= cfg_data;
				CFG_MIN:      min_q <= cfg_data[15:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b0;
			ws_q        <= '0;
			red_sum_q   <= '0;
			ir_sum_q    <= '0;
			ratio_sum_q <= '0;
			count_q     <= '0;
		end else begin
			if (cmd.do_start) begin
				armed_q     <= 1'b1;
				ws_q        <= now_q;
				red_sum_q   <= '0;
				ir_sum_q    <= '0;
				ratio_sum_q <= '0;
				count_q     <= '0;
			end
			if (cmd.do_accum) begin
				red_sum_q   <= red_sum_q + 31'(red_mag);
				ir_sum_q    <= ir_sum_q + 31'(ir_mag);
				ratio_sum_q <= ratio_sum_q + 32'(ratio_sat);
				count_q     <= count_q + 16'd1;
			end
			if (cmd.do_close)
				armed_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q      <= func;
			red_q       <= red_sample;
			ir_q        <= ir_sample;
			now_q       <= now_ms;
			done_q      <= 1'b0;
			succ_q      <= 1'b0;
			avg_red_q   <= '0;
			avg_ir_q    <= '0;
			avg_ratio_q <= '0;
		end
		if (cmd.do_close) begin
			done_q <= 1'b1;
			succ_q <= stat.success;
		end
		if (div_done) begin
			case (cmd.div_sel)
				DIV_RED:  avg_red_q   <= div_quo[14:0];
				DIV_IR:   avg_ir_q    <= div_quo[14:0];
				DIV_RSUM: avg_ratio_q <= div_quo[15:0];
				default:  ;
			endcase
		end
		if (cmd.load_out) begin
			capturing   <= armed_q;
			done_res    <= done_q;
			success     <= succ_q;
			avg_red     <= avg_red_q;
			avg_ir      <= avg_ir_q;
			avg_ratio   <= avg_ratio_q;
			valid_count <= count_q;
		end
	end
endmodule
`default_nettype wire

@@ src/brav_ctrl.sv @@
// Controller state machine: sequences evaluation, divisions and result hand-off.
// Depends on brav_pkg.
`default_nettype none
module brav_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	input  wire brav_pkg::stat_t stat,
	output brav_pkg::cmd_t       cmd
);
	import brav_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.div_sel = DIV_RATIO;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (stat.is_start) begin
					cmd.do_start = 1'b1;
					state_d      = ST_EMIT;
				end else if (!stat.armed)
					state_d = ST_EMIT;
				else if (stat.pair_ok)
					state_d = ST_RAT_GO;
				else
					state_d = ST_CHECK;
			end
			ST_RAT_GO: begin
				cmd.div_start = 1'b1;
				state_d       = ST_RAT_WAIT;
			end
			ST_RAT_WAIT: begin
				if (stat.div_done) begin
					cmd.do_accum = 1'b1;
					state_d      = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = ST_EMIT;
				if (stat.close_hit) begin
					cmd.do_close = 1'b1;
					if (stat.success && !stat.cnt_zero)
						state_d = ST_AVR_GO;
				end
			end
			ST_AVR_GO: begin
				cmd.div_sel   = DIV_RED;
				cmd.div_start = 1'b1;
				state_d       = ST_AVR_WAIT;
			end
			ST_AVR_WAIT: begin
				cmd.div_sel = DIV_RED;
				if (stat.div_done)
					state_d = ST_AVI_GO;
			end
			ST_AVI_GO: begin
				cmd.div_sel   = DIV_IR;
				cmd.div_start = 1'b1;
				state_d       = ST_AVI_WAIT;
			end
			ST_AVI_WAIT: begin
				cmd.div_sel = DIV_IR;
				if (stat.div_done)
					state_d = ST_AVQ_GO;
			end
			ST_AVQ_GO: begin
				cmd.div_sel   = DIV_RSUM;
				cmd.div_start = 1'b1;
				state_d       = ST_AVQ_WAIT;
			end
			ST_AVQ_WAIT: begin
				cmd.div_sel = DIV_RSUM;
				if (stat.div_done)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !stat.div_busy)
		else $error("divider started while busy");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> (state_q == ST_RAT_WAIT || state_q == ST_AVR_WAIT ||
			state_q == ST_AVI_WAIT || state_q == ST_AVQ_WAIT))
		else $error("divider finished outside a wait state");

	a_close_armed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_close |-> stat.armed)
		else $error("window closed while not armed");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid)
		else $error("result loaded without valid");
endmodule
`default_nettype wire

@@ src/baseline_ratio_averager_top.sv @@
// Baseline ratio averager top level: joins controller and datapath.
// Depends on brav_pkg, brav_if, brav_ctrl, brav_dp.
//
// Usage:
//   in_ch carries one item per handshake: func = 1 starts a capture window at
//   now_ms, func = 0 is a red/infrared sample. Every input item yields exactly
//   one result item on out_ch.
//   cfg_we/cfg_idx/cfg_data write the window duration (index 0) and minimum
//   accepted count (index 1); write only while the block is idle.
// Flow:
//   One item at a time; in_ch.ready is high only in idle, from the cycle after
//   the result register is loaded. Accept to result register: start item or
//   unarmed sample via evaluation and emit, rejected sample also the window
//   check, accepted sample also the ratio division (33-step shared divider).
//   A window-closing sample with success can add three averaging divisions.
//   The result register lets the next item be accepted while a result waits.
// Reset and stall:
//   arst_n clears the window, sums and count and restores the default config.
//   If out_ch is stalled, the next item finishes its work and then waits until
//   the pending result is taken; no item is lost or repeated.
`default_nettype none
module baseline_ratio_averager_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	brav_in_if.sink                 in_ch,
	brav_out_if.source              out_ch,
	input  wire logic               cfg_we,
	input  wire brav_pkg::cfg_idx_t cfg_idx,
	input  wire logic [31:0]        cfg_data
);
	import brav_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	brav_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	brav_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.func        (in_ch.func),
		.red_sample  (in_ch.red_sample),
		.ir_sample   (in_ch.ir_sample),
		.now_ms      (in_ch.now_ms),
		.cmd         (cmd),
		.stat        (stat),
		.capturing   (out_ch.capturing),
		.done_res    (out_ch.done_res),
		.success     (out_ch.success),
		.avg_red     (out_ch.avg_red),
		.avg_ir      (out_ch.avg_ir),
		.avg_ratio   (out_ch.avg_ratio),
		.valid_count (out_ch.valid_count)
	);
endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for baseline_ratio_averager_top: random-paced item driver,
// stalling result monitor and an in-bench model of the capture window.
// Depends on brav_pkg, brav_if and the RTL under src.
module tb;
	import brav_pkg::*;

	typedef struct packed {
		logic               func;
		logic signed [15:0] red;
		logic signed [15:0] ir;
		logic [31:0]        stamp;
		logic               hold;
	} sample_item_t;

	typedef struct packed {
		logic        capturing;
		logic        done_res;
		logic        success;
		logic [14:0] avg_red;
		logic [14:0] avg_ir;
		logic [15:0] avg_ratio;
		logic [15:0] valid_count;
	} window_result_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     cfg_we = 1'b0;
	cfg_idx_t cfg_idx = CFG_DURATION;
	logic [31:0] cfg_data = '0;

	brav_in_if  in_ch();
	brav_out_if out_ch();

	baseline_ratio_averager_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// window model
	logic [31:0] m_duration = DURATION_RESET;
	logic [15:0] m_min = MIN_RESET;
	logic        m_armed = 1'b0;
	logic [31:0] m_start = '0;
	logic [30:0] m_red_sum = '0;
	logic [30:0] m_ir_sum = '0;
	logic [31:0] m_ratio_sum = '0;
	logic [15:0] m_count = '0;

	sample_item_t   sample_queue[$];
	window_result_t window_results_q[$];
	sample_item_t   cur_item;
	int accepted_cnt = 0;
	int checked_cnt = 0;
	int mismatch_cnt = 0;
	int planned = 0;
	int settings = 0;
	int closes = 0;
	int full_baselines = 0;
	int burst_left = 0;
	int gap_left = 0;
	int run_left = 0;
	int stall_left = 0;
	logic [31:0] cur_duration = DURATION_RESET;

	function automatic logic [31:0] round_mean(input logic [31:0] sum, input logic [15:0] n);
		logic [63:0] t;
		if (n == 0)
			return '0;
		t = {32'd0, sum} + {48'd0, n >> 1};
		return t / n;
	endfunction

	function automatic window_result_t step_window(input sample_item_t it);
		window_result_t r;
		int red;
		int ir;
		logic [31:0] ratio;
		logic [31:0] elapsed;
		r = '0;
		red = $signed(it.red);
		ir = $signed(it.ir);
		if (it.func) begin
			m_armed = 1'b1;
			m_start = it.stamp;
			m_red_sum = '0;
			m_ir_sum = '0;
			m_ratio_sum = '0;
			m_count = '0;
		end else if (m_armed) begin
			if (red >= 2 && ir >= 2 && 100 * red > ir && red < 10 * ir && m_count != CNT_FULL) begin
				ratio = (red << RATIO_FRAC_BITS) / ir;
				if (ratio > RATIO_MAX)
					ratio = RATIO_MAX;
				m_red_sum = m_red_sum + red[30:0];
				m_ir_sum = m_ir_sum + ir[30:0];
				m_ratio_sum = m_ratio_sum + ratio;
				m_count = m_count + 16'd1;
			end
			elapsed = it.stamp - m_start;
			if (elapsed >= m_duration) begin
				m_armed = 1'b0;
				r.done_res = 1'b1;
				if (m_count >= m_min) begin
					r.success = 1'b1;
					r.avg_red = round_mean({1'b0, m_red_sum}, m_count);
					r.avg_ir = round_mean({1'b0, m_ir_sum}, m_count);
					r.avg_ratio = round_mean(m_ratio_sum, m_count);
				end
			end
		end
		r.capturing = m_armed;
		r.valid_count = m_count;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
		input logic [31:0] want);
		mismatch_cnt++;
		if (mismatch_cnt <= 40)
			$display("[%0t] result %0d: %s got %h want %h", $time, checked_cnt, field, got, want);
	endtask

	// item driver: bursts with random gaps; a held item waits for all results
	always @(posedge clk) begin : drive_proc
		logic acc;
		logic nv;
		sample_item_t nxt;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			acc = in_ch.valid && in_ch.ready;
			nv = in_ch.valid && !acc;
			if (acc) begin
				window_results_q.push_back(step_window(cur_item));
				accepted_cnt <= accepted_cnt + 1;
			end
			if (!nv) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (sample_queue.size() != 0 &&
					(!sample_queue[0].hold || (!acc && accepted_cnt == checked_cnt))) begin
					nxt = sample_queue.pop_front();
					cur_item = nxt;
					in_ch.func <= nxt.func;
					in_ch.red_sample <= nxt.red;
					in_ch.ir_sample <= nxt.ir;
					in_ch.now_ms <= nxt.stamp;
					nv = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
					end
				end
			end
			in_ch.valid <= nv;
		end
	end

	// result monitor with its own stall pattern
	always @(posedge clk) begin : watch_proc
		window_result_t got;
		window_result_t want;
		logic rdy;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			run_left = 0;
			stall_left = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.capturing, out_ch.done_res, out_ch.success, out_ch.avg_red,
					out_ch.avg_ir, out_ch.avg_ratio, out_ch.valid_count};
				if (checked_cnt == accepted_cnt) begin
					report_mismatch("unexpected result, valid_count", got.valid_count, '0);
				end else begin
					want = window_results_q.pop_front();
					if (got.capturing !== want.capturing)
						report_mismatch("capturing", got.capturing, want.capturing);
					if (got.done_res !== want.done_res)
						report_mismatch("done_res", got.done_res, want.done_res);
					if (got.success !== want.success)
						report_mismatch("success", got.success, want.success);
					if (got.avg_red !== want.avg_red)
						report_mismatch("avg_red", got.avg_red, want.avg_red);
					if (got.avg_ir !== want.avg_ir)
						report_mismatch("avg_ir", got.avg_ir, want.avg_ir);
					if (got.avg_ratio !== want.avg_ratio)
						report_mismatch("avg_ratio", got.avg_ratio, want.avg_ratio);
					if (got.valid_count !== want.valid_count)
						report_mismatch("valid_count", got.valid_count, want.valid_count);
					if (want.done_res)
						closes++;
					if (want.success)
						full_baselines++;
					checked_cnt <= checked_cnt + 1;
				end
			end
			if (run_left > 0) begin
				run_left--;
				rdy = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else begin
				run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) :
					$urandom_range(1, 20);
				stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
				rdy = 1'b1;
			end
			out_ch.ready <= rdy;
		end
	end

	task automatic push_item(input logic func, input logic [15:0] red, input logic [15:0] ir,
		input logic [31:0] stamp, input logic hold);
		sample_queue.push_back('{func, red, ir, stamp, hold});
		planned++;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (sample_queue.size() != 0 || in_ch.valid || accepted_cnt != checked_cnt);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		if (idx == CFG_DURATION) begin
			m_duration = val;
			cur_duration = val;
		end else begin
			m_min = val[15:0];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_window(input logic [31:0] duration, input logic [31:0] min_val);
		write_reg(CFG_DURATION, duration);
		write_reg(CFG_MIN, min_val);
		settings++;
	endtask

	// mostly accepted pairs, some on the acceptance edges, some arbitrary
	task automatic pick_pair(output logic [15:0] red, output logic [15:0] ir);
		int kind;
		int i;
		int lo;
		int hi;
		kind = $urandom_range(0, 9);
		if (kind < 7) begin
			i = (kind < 2) ? $urandom_range(2, 200) : $urandom_range(2, 32767);
			lo = i / 100 + 1;
			if (lo < 2)
				lo = 2;
			hi = 10 * i - 1;
			if (hi > 32767)
				hi = 32767;
			red = $urandom_range(lo, hi);
			ir = i;
		end else if (kind == 7) begin
			case ($urandom_range(0, 3))
				0: begin
					i = $urandom_range(2, 3276);
					ir = i;
					red = 10 * i;
				end
				1: begin
					i = $urandom_range(2, 3276);
					ir = i;
					red = 10 * i - 1;
				end
				2: begin
					i = $urandom_range(2, 327);
					red = i;
					ir = 100 * i;
				end
				default: begin
					i = $urandom_range(2, 327);
					red = i;
					ir = 100 * i - 1;
				end
			endcase
		end else begin
			red = $urandom();
			ir = $urandom();
		end
	endtask

	task automatic gen_window(input logic hold_first);
		logic [31:0] base;
		logic [15:0] r;
		logic [15:0] x;
		longint e;
		longint stride;
		int cap;
		int n;
		base = $urandom();
		push_item(1'b1, $urandom(), $urandom(), base, hold_first);
		cap = $urandom_range(1, 30);
		stride = cur_duration / 6;
		e = 0;
		for (n = 0; n < cap; n++) begin
			e += $urandom_range(0, stride);
			if (e >= cur_duration)
				break;
			pick_pair(r, x);
			push_item(1'b0, r, x, base + e[31:0], 1'b0);
		end
		// now and then the window is left open and the next start restarts it
		if ($urandom_range(0, 9) != 0) begin
			e = cur_duration;
			if (cur_duration < 32'hFFFF_FFFC)
				e += $urandom_range(0, 3);
			pick_pair(r, x);
			push_item(1'b0, r, x, base + e[31:0], 1'b0);
			repeat ($urandom_range(0, 1))
				push_item(1'b0, $urandom(), $urandom(), $urandom(), 1'b0);
		end
		if ($urandom_range(0, 14) == 0)
			push_item($urandom_range(0, 1), $urandom(), $urandom(), $urandom(), 1'b0);
	endtask

	initial begin : stimulus
		int p;
		int goal;
		in_ch.valid = 1'b0;
		in_ch.func = 1'b0;
		in_ch.red_sample = '0;
		in_ch.ir_sample = '0;
		in_ch.now_ms = '0;
		out_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: 60 s window, 100 pairs
		push_item(1'b0, 16'd100, 16'd100, 32'd0, 1'b0);
		push_item(1'b1, 16'h7FFF, 16'h8000, 32'hFFFF_F000, 1'b1);
		push_item(1'b0, 16'h7FFF, 16'h7FFF, 32'hFFFF_F010, 1'b0);
		push_item(1'b0, 16'h8000, 16'h8000, 32'hFFFF_F020, 1'b0);
		push_item(1'b0, 16'd1, 16'd5, 32'hFFFF_F030, 1'b0);
		push_item(1'b0, 16'd2, 16'd2, 32'hFFFF_F040, 1'b0);
		push_item(1'b0, 16'd2, 16'd200, 32'hFFFF_F050, 1'b0);
		push_item(1'b0, 16'd3, 16'd200, 32'hFFFF_F060, 1'b0);
		push_item(1'b0, 16'd20, 16'd2, 32'hFFFF_F070, 1'b0);
		push_item(1'b0, 16'd19, 16'd2, 32'hFFFF_F080, 1'b0);
		push_item(1'b0, 16'd32767, 16'd3277, 32'hFFFF_F090, 1'b0);
		push_item(1'b0, 16'hFFFF, 16'h7FFF, 32'hFFFF_F0A0, 1'b0);
		// restart while armed, then close across the time wrap
		push_item(1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FF00, 1'b0);
		push_item(1'b0, 16'd5000, 16'd7000, 32'hFFFF_FFFF, 1'b0);
		push_item(1'b0, 16'd11, 16'd3, 32'h0000_E95F, 1'b0);
		push_item(1'b0, 16'd9, 16'd4, 32'h0000_E960, 1'b0);
		push_item(1'b0, 16'd100, 16'd100, 32'h0000_E961, 1'b0);
		wait_idle();

		// zero window, zero minimum
		set_window(32'd0, 32'd0);
		push_item(1'b1, 16'd0, 16'd0, 32'd42, 1'b0);
		push_item(1'b0, 16'd0, 16'd0, 32'd42, 1'b0);
		push_item(1'b1, 16'd0, 16'd0, 32'd100, 1'b0);
		push_item(1'b0, 16'd1234, 16'd567, 32'd7, 1'b0);
		wait_idle();

		// longest window, largest minimum
		set_window(32'hFFFF_FFFF, 32'd65535);
		push_item(1'b1, 16'd0, 16'd0, 32'd5, 1'b0);
		push_item(1'b0, 16'd300, 16'd200, 32'd3, 1'b0);
		push_item(1'b0, 16'd301, 16'd200, 32'd4, 1'b0);
		wait_idle();
		write_reg(CFG_MIN, 32'd2);
		settings++;
		push_item(1'b1, 16'd0, 16'd0, 32'd0, 1'b0);
		push_item(1'b0, 16'd7, 16'd3, 32'hFFFF_FFFE, 1'b0);
		push_item(1'b0, 16'd8, 16'd3, 32'hFFFF_FFFF, 1'b0);
		wait_idle();

		goal = planned;
		for (p = 0; p < 8; p++) begin
			case (p)
				0: set_window(32'd1000, 32'd6);
				1: set_window(32'd0, 32'd0);
				2: set_window(32'd200, 32'd65535);
				3: set_window(32'hFFFF_FFFF, 32'd3);
				4: set_window(32'd5000, {$urandom_range(0, 65535), 16'd12});
				5: set_window(32'd60000, 32'd1);
				default: set_window($urandom_range(0, 4000), $urandom_range(0, 20));
			endcase
			goal += 195;
			while (planned < goal)
				gen_window($urandom_range(0, 9) == 0);
			wait_idle();
		end

		repeat (150) @(posedge clk);
		$display("%0d items over %0d register settings checked", planned, settings);
		$display("%0d capture windows closed, %0d of them with a full baseline",
			closes, full_baselines);
		if (mismatch_cnt == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("run timed out with %0d results outstanding", accepted_cnt - checked_cnt);
		$display("end of test: mismatches");
		$finish;
	end
endmodule
